FILE: rtl/core/vfd_pkg.sv
// shared types and constants for the vadpcm frame decoder
// depends on nothing; imported by vfd_front, vfd_queue, vfd_back and the top level
package vfd_pkg;

  localparam int MAX_PREDICTORS   = 16;
  localparam int SAMPLES_PER_HALF = 8;
  localparam int COEF_DEPTH       = MAX_PREDICTORS * 2 * SAMPLES_PER_HALF;
  localparam int COEF_ADDR_W      = $clog2(COEF_DEPTH);
  localparam int TAP_W            = $clog2(SAMPLES_PER_HALF);
  localparam int PRED_W           = $clog2(MAX_PREDICTORS);
  localparam int PRED_COUNT_W     = 5;
  localparam int SHIFT_W          = 4;
  localparam int CODE_W           = 4;
  localparam int NUM_CODES        = 2 * SAMPLES_PER_HALF;
  localparam int PAYLOAD_W        = 64;
  localparam int SAMPLE_W         = 16;
  localparam int OPND_W           = 19;
  localparam int ACC_W            = 32;
  localparam int FRAC_BITS        = 11;
  localparam int QUEUE_DEPTH      = 2;
  localparam int IN_DATA_W        = 104;
  localparam int OUT_DATA_W       = SAMPLES_PER_HALF * SAMPLE_W;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_CODEC = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRED_COUNT  = 1'd1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_kind_t;

  // codes hold sixteen 4-bit signed codes, code i at bits 63-4i down
  typedef struct packed {
    cmd_kind_t                kind;
    logic                     clear;
    logic [SHIFT_W-1:0]       shift;
    logic [PRED_W-1:0]        pred;
    logic [PAYLOAD_W-1:0]     codes;
    logic [COEF_ADDR_W-1:0]   coef_addr;
    logic signed [SAMPLE_W-1:0] coef_value;
  } cmd_t;

endpackage

FILE: rtl/core/vfd_front.sv
// front end: accepts input items, classifies them and unpacks frame codes
// depends on vfd_pkg; feeds vfd_queue
module vfd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vfd_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  input  logic                             small_codec,
  input  logic [vfd_pkg::PRED_COUNT_W-1:0] predictor_count,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output vfd_pkg::cmd_t                    cmd
);
  import vfd_pkg::*;

  logic       operation;
  logic [7:0] frame_header;
  logic [PAYLOAD_W-1:0] frame_payload;
  logic       new_sound;
  logic [COEF_ADDR_W-1:0] coef_address;
  logic signed [SAMPLE_W-1:0] coef_value;
  logic       pred_ok;
  logic       keep;
  logic [PAYLOAD_W-1:0] codes;
  cmd_t       cmd_in;

  assign operation     = s_tuser;
  assign frame_header  = s_tdata[7:0];
  assign frame_payload = s_tdata[71:8];
  assign new_sound     = s_tdata[72];
  assign coef_address  = s_tdata[80:73];
  assign coef_value    = s_tdata[96:81];

  assign pred_ok = {1'b0, frame_header[PRED_W-1:0]} < predictor_count;

  // small codec codes are 2-bit; widen them to the 4-bit layout
  always_comb begin
    codes = frame_payload;
    if (small_codec) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        codes[PAYLOAD_W-1-CODE_W*i -: CODE_W] =
          {{2{frame_payload[PAYLOAD_W-1-2*i]}}, frame_payload[PAYLOAD_W-1-2*i -: 2]};
      end
    end
  end

  always_comb begin
    cmd_in.clear      = new_sound;
    cmd_in.shift      = frame_header[7:4];
    cmd_in.pred       = frame_header[PRED_W-1:0];
    cmd_in.codes      = codes;
    cmd_in.coef_addr  = coef_address;
    cmd_in.coef_value = coef_value;
    if (operation) begin
      cmd_in.kind = CMD_WRITE;
      keep        = 1'b1;
    end else if (pred_ok) begin
      cmd_in.kind = CMD_DECODE;
      keep        = 1'b1;
    end else begin
      cmd_in.kind = CMD_CLEAR;
      keep        = new_sound;
    end
  end

  assign s_tready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      cmd_valid <= keep;
    end else if (cmd_valid && cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/vfd_queue.sv
// short command queue between front end and back end
// depends on vfd_pkg
module vfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  vfd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output vfd_pkg::cmd_t pop_cmd
);
  import vfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/vfd_back.sv
// back end: coefficient memory, multiply-accumulate sequencer, history and result register
// depends on vfd_pkg; takes commands from vfd_queue
module vfd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  vfd_pkg::cmd_t                   cmd,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vfd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tlast
);
  import vfd_pkg::*;

  localparam int TERM_W = $clog2(SAMPLES_PER_HALF + 2);
  localparam int PROD_W = SAMPLE_W + OPND_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-FRAC_BITS-1:0] sh;
    sh = (ACC_W-FRAC_BITS)'(v >>> FRAC_BITS);
    if (sh < -(ACC_W-FRAC_BITS)'(32768)) begin
      clamp16 = 16'sh8000;
    end else if (sh > (ACC_W-FRAC_BITS)'(32767)) begin
      clamp16 = 16'sh7fff;
    end else begin
      clamp16 = sh[SAMPLE_W-1:0];
    end
  endfunction

  state_t state;
  logic   half;
  logic [TAP_W-1:0]   j;
  logic [TERM_W-1:0]  t;
  logic [SHIFT_W-1:0] shift;
  logic [PRED_W-1:0]  pred;
  logic [PAYLOAD_W-1:0] codes;
  logic signed [SAMPLE_W-1:0] hist_last;
  logic signed [SAMPLE_W-1:0] hist_before_last;
  logic signed [SAMPLE_W-1:0] res [SAMPLES_PER_HALF];
  logic signed [SAMPLE_W-1:0] pcm [SAMPLES_PER_HALF];

  logic signed [SAMPLE_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [SAMPLE_W-1:0] coef_q;
  logic                       mem_we;
  logic [COEF_ADDR_W-1:0]     rd_addr;

  logic [CODE_W-1:0] code_arr [NUM_CODES];
  logic              issue;
  logic              term_last;
  logic [TAP_W-1:0]  tap;
  logic              row;
  logic [TAP_W-1:0]  k;
  logic signed [OPND_W-1:0] opnd;
  logic signed [OPND_W-1:0] cj;

  logic                     s1_valid, s1_first, s1_last;
  logic [TAP_W-1:0]         s1_j;
  logic signed [OPND_W-1:0] s1_op, s1_cj;
  logic                     s2_valid, s2_first, s2_last;
  logic [TAP_W-1:0]         s2_j;
  logic signed [ACC_W-1:0]  s2_prod;
  logic signed [OPND_W-1:0] s2_cj;
  logic signed [PROD_W-1:0] mult_full;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      code_arr[i] = codes[PAYLOAD_W-1-CODE_W*i -: CODE_W];
    end
  end

  assign issue     = state == ST_RUN;
  assign term_last = t == TERM_W'({1'b0, j}) + 1'b1;
  assign k         = TAP_W'(t - TERM_W'(2));

  // term 0: before-last history, term 1: last history, then earlier codes of this half
  always_comb begin
    if (t == TERM_W'(0)) begin
      row  = 1'b0;
      tap  = j;
      opnd = OPND_W'(hist_before_last);
    end else if (t == TERM_W'(1)) begin
      row  = 1'b1;
      tap  = j;
      opnd = OPND_W'(hist_last);
    end else begin
      row  = 1'b1;
      tap  = TAP_W'(TERM_W'(j) - t + 1'b1);
      opnd = OPND_W'(signed'(code_arr[{half, k}])) <<< shift;
    end
    cj = OPND_W'(signed'(code_arr[{half, j}])) <<< shift;
  end

  assign rd_addr = {pred, row, tap};
  assign mem_we  = state == ST_IDLE && cmd_valid && cmd.kind == CMD_WRITE;
  assign cmd_pop = state == ST_IDLE && cmd_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[cmd.coef_addr] <= cmd.coef_value;
    end
    coef_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  assign mult_full = coef_q * s1_op;

  always_ff @(posedge clk) begin
    s1_first <= t == TERM_W'(0);
    s1_last  <= term_last;
    s1_j     <= j;
    s1_op    <= opnd;
    s1_cj    <= cj;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_j     <= s1_j;
    s2_prod  <= ACC_W'(mult_full);
    s2_cj    <= s1_cj;
  end

  assign acc_next = (s2_first ? (ACC_W'(s2_cj) <<< FRAC_BITS) : acc) + s2_prod;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
      if (s2_last) begin
        res[s2_j] <= clamp16(acc_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      hist_last        <= '0;
      hist_before_last <= '0;
      m_tvalid         <= 1'b0;
      half             <= 1'b0;
      j                <= '0;
      t                <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind != CMD_WRITE && cmd.clear) begin
              hist_last        <= '0;
              hist_before_last <= '0;
            end
            if (cmd.kind == CMD_DECODE) begin
              shift <= cmd.shift;
              pred  <= cmd.pred;
              codes <= cmd.codes;
              half  <= 1'b0;
              j     <= '0;
              t     <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (term_last) begin
            t <= '0;
            if (j == TAP_W'(SAMPLES_PER_HALF - 1)) begin
              state <= ST_DRAIN;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            t <= t + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid         <= 1'b1;
            m_tlast          <= half;
            pcm              <= res;
            hist_before_last <= res[SAMPLES_PER_HALF-2];
            hist_last        <= res[SAMPLES_PER_HALF-1];
            if (half) begin
              state <= ST_IDLE;
            end else begin
              half  <= 1'b1;
              j     <= '0;
              t     <= '0;
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < SAMPLES_PER_HALF; i++) begin
      m_tdata[SAMPLE_W*i +: SAMPLE_W] = pcm[i];
    end
  end

endmodule

FILE: rtl/core/vadpcm_frame_decoder_unit.sv
// vadpcm frame decoder, order-2 predictor, 4-bit or 2-bit small codes
// depends on vfd_pkg, vfd_front, vfd_queue and vfd_back
//
// usage:
// - input stream s_*: one item per frame or coefficient write. s_tuser is the
//   operation (0 decode, 1 coefficient write); s_tdata carries the other fields.
// - output stream m_*: two items per decoded frame, eight samples each;
//   m_tlast marks the second half of the frame.
// - cfg_we/cfg_index/cfg_data write small_codec (index 0) and predictor_count
//   (index 1); write them only while the block is idle.
// - coefficients must be loaded by write items before frames that use them.
// - a decode runs, in each half, 44 multiply-accumulate terms through the single
//   16x19 multiplier, one coefficient memory read per cycle, then drains the
//   pipeline and hands off the half.
// - frames with an out-of-range predictor give no result (new_sound still
//   clears the history); those without new_sound are dropped in the front end.
// - the front end register and a 2-entry queue keep accepting, until they are full,
//   while the back end works or the output is stalled; a stalled m_tready holds the
//   result and halts the back end before it hands off the next half.
// - rst (synchronous) clears history, configuration and all valid flags; the
//   coefficient memory is not cleared.
module vadpcm_frame_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // operation
  input  logic                            s_tuser,
  // frame_header, frame_payload, new_sound, coef_address, coef_value, zero pad
  input  logic [vfd_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pcm_0, pcm_1, pcm_2, pcm_3, pcm_4, pcm_5, pcm_6, pcm_7
  output logic [vfd_pkg::OUT_DATA_W-1:0]  m_tdata,
  // second_half
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [vfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vfd_pkg::*;

  logic                    small_codec;
  logic [PRED_COUNT_W-1:0] predictor_count;
  logic                    f_valid;
  logic                    f_ready;
  cmd_t                    f_cmd;
  logic                    q_valid;
  logic                    q_pop;
  cmd_t                    q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_codec     <= 1'b0;
      predictor_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMALL_CODEC: small_codec     <= cfg_data[0];
        CFG_PRED_COUNT:  predictor_count <= cfg_data[PRED_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  vfd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .small_codec     (small_codec),
    .predictor_count (predictor_count),
    .cmd_valid       (f_valid),
    .cmd_ready       (f_ready),
    .cmd             (f_cmd)
  );

  vfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  vfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: tb/tb_vadpcm_frame_decoder_unit.sv
// self-checking testbench for vadpcm_frame_decoder_unit: frame decodes and coefficient writes
// go in on the input stream, and a local order-2 predictor checks each half-frame that comes out
// depends on vfd_pkg and the rtl of vadpcm_frame_decoder_unit
`timescale 1ns / 1ps

module tb_vadpcm_frame_decoder_unit;
  import vfd_pkg::*;

  localparam logic OP_DECODE    = 1'b0;
  localparam logic OP_WRITE     = 1'b1;
  localparam int   DRAIN_CYCLES = 150;
  localparam int   HOLD_CYCLES  = 700;
  localparam int   CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [OUT_DATA_W-1:0] pcm;
    logic                  last;
  } half_frame_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic                   s_tuser   = 1'b0;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // local copy of the decoder state
  logic signed [15:0]     coef_mirror [COEF_DEPTH];
  logic signed [15:0]     hist_last = '0;
  logic signed [15:0]     hist_prev = '0;
  logic                   cfg_small = 1'b0;
  int unsigned            cfg_pred_count = 0;

  half_frame_t            pcm_expected [$];
  int                     mismatch_count = 0;
  int                     sender_idle_pct = 0;
  int                     receiver_stall_pct = 0;
  int                     hold_requests = 0;
  int                     hold_taken = 0;
  int                     hold_left = 0;
  int                     cycle_count = 0;

  vadpcm_frame_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : check_pcm
    half_frame_t want;
    int i;
    if (!rst && m_tvalid && m_tready) begin
      if (pcm_expected.size() == 0) begin
        $error("unexpected item: second_half %0b", m_tlast);
        mismatch_count++;
      end else begin
        want = pcm_expected.pop_front();
        for (i = 0; i < SAMPLES_PER_HALF; i++) begin
          if (m_tdata[16*i +: 16] !== want.pcm[16*i +: 16]) begin
            $error("pcm_%0d: expected %0d, got %0d", i,
                   $signed(want.pcm[16*i +: 16]), $signed(m_tdata[16*i +: 16]));
            mismatch_count++;
          end
        end
        if (m_tlast !== want.last) begin
          $error("second_half: expected %0b, got %0b", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  task automatic predict_frame(input logic [7:0] hdr, input logic [63:0] pay,
                               input logic fresh);
    logic [3:0]         shift;
    logic [3:0]         pred;
    int unsigned        limit;
    int                 base;
    int                 idx;
    logic [1:0]         duo;
    logic [3:0]         nib;
    longint             code [SAMPLES_PER_HALF];
    longint             acc;
    logic [31:0]        wrapped;
    int                 shifted;
    logic signed [15:0] smp [SAMPLES_PER_HALF];
    half_frame_t        res;
    if (fresh) begin
      hist_last = '0;
      hist_prev = '0;
    end
    shift = hdr[7:4];
    pred  = hdr[3:0];
    limit = (cfg_pred_count < MAX_PREDICTORS) ? cfg_pred_count : MAX_PREDICTORS;
    if (pred >= limit) return;
    base = pred * 16;
    for (int half = 0; half < 2; half++) begin
      for (int j = 0; j < SAMPLES_PER_HALF; j++) begin
        idx = half * SAMPLES_PER_HALF + j;
        if (cfg_small) begin
          duo     = pay[63 - 2*idx -: 2];
          code[j] = longint'($signed(duo)) * (longint'(1) << shift);
        end else begin
          nib     = pay[63 - 4*idx -: 4];
          code[j] = longint'($signed(nib)) * (longint'(1) << shift);
        end
      end
      for (int j = 0; j < SAMPLES_PER_HALF; j++) begin
        acc = longint'(coef_mirror[base + j]) * hist_prev
            + longint'(coef_mirror[base + 8 + j]) * hist_last
            + code[j] * 2048;
        for (int k = 0; k < j; k++)
          acc += longint'(coef_mirror[base + 8 + j - k - 1]) * code[k];
        wrapped = acc[31:0];
        shifted = $signed(wrapped) >>> FRAC_BITS;
        if (shifted > 32767) smp[j] = 16'sh7FFF;
        else if (shifted < -32768) smp[j] = -16'sh8000;
        else smp[j] = shifted[15:0];
        res.pcm[16*j +: 16] = smp[j];
      end
      res.last = (half == 1);
      pcm_expected.insert(pcm_expected.size(), res);
      hist_prev = smp[SAMPLES_PER_HALF - 2];
      hist_last = smp[SAMPLES_PER_HALF - 1];
    end
  endtask

  // one item on the input stream, predicted at the edge that accepts it
  task automatic send_item(input logic op, input logic [7:0] hdr, input logic [63:0] pay,
                           input logic fresh, input logic [7:0] addr, input logic [15:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, val, addr, fresh, pay, hdr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE) coef_mirror[addr] = val;
    else predict_frame(hdr, pay, fresh);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [63:0] pay, input logic fresh);
    send_item(OP_DECODE, hdr, pay, fresh, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_coef(input logic [7:0] addr, input logic [15:0] val);
    send_item(OP_WRITE, 8'($urandom), {$urandom, $urandom}, 1'($urandom), addr, val);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SMALL_CODEC) cfg_small = val[0];
    else cfg_pred_count = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // predictor 15 all max, predictor 14 all min, the rest moderate
  task automatic load_coefficients();
    logic [15:0] val;
    for (int a = 0; a < COEF_DEPTH; a++) begin
      if (a >= 15 * 16) val = 16'h7FFF;
      else if (a >= 14 * 16) val = 16'h8000;
      else val = 16'($urandom_range(8191) - 4096);
      send_coef(8'(a), val);
    end
    wait_idle();
  endtask

  task automatic test_no_predictors();
    write_reg(CFG_PRED_COUNT, 0);
    send_frame(8'h00, {$urandom, $urandom}, 1'b0);
    wait_idle();
  endtask

  task automatic test_four_bit();
    write_reg(CFG_SMALL_CODEC, 0);
    write_reg(CFG_PRED_COUNT, MAX_PREDICTORS);
    send_frame(8'h00, 64'h0, 1'b1);
    send_frame(8'h00, 64'h7777_7777_7777_7777, 1'b0);
    send_frame(8'hF0, 64'h8888_8888_8888_8888, 1'b0);
    // full-scale coefficients and codes wrap the accumulator
    send_frame(8'hFF, 64'h7777_7777_7777_7777, 1'b0);
    send_frame(8'hFF, 64'h7777_7777_7777_7777, 1'b0);
    send_frame(8'hFE, 64'h8888_8888_8888_8888, 1'b0);
    send_frame(8'hC5, {$urandom, $urandom}, 1'b0);
    send_coef(8'h00, 16'h8000);
    send_coef(8'hFF, 16'h7FFF);
    send_frame(8'h30, {$urandom, $urandom}, 1'b0);
    send_frame(8'h4F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_out_of_range();
    write_reg(CFG_PRED_COUNT, 3);
    send_frame(8'h13, {$urandom, $urandom}, 1'b0);
    // dropped, but the history is still cleared
    send_frame(8'h2F, {$urandom, $urandom}, 1'b1);
    send_frame(8'h22, {$urandom, $urandom}, 1'b0);
    wait_idle();
  endtask

  task automatic test_small_codec();
    write_reg(CFG_SMALL_CODEC, 1);
    write_reg(CFG_PRED_COUNT, MAX_PREDICTORS);
    send_frame(8'h00, {32'h5555_5555, 32'hFFFF_FFFF}, 1'b1);
    send_frame(8'hF7, {32'hAAAA_AAAA, $urandom}, 1'b0);
    send_frame(8'hF1, {32'hFFFF_FFFF, $urandom}, 1'b0);
    send_frame(8'h9B, {$urandom, $urandom}, 1'b1);
    wait_idle();
  endtask

  // long receiver hold while frames keep coming, so the input side stalls
  task automatic test_backpressure();
    write_reg(CFG_SMALL_CODEC, 0);
    set_idling(0, 0);
    hold_requests++;
    for (int n = 0; n < 8; n++)
      send_frame({4'($urandom_range(11)), 4'($urandom)}, {$urandom, $urandom}, n == 0);
    wait_idle();
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct,
                                  input logic small_sel, input int unsigned pred_count,
                                  input int n_items);
    int          roll;
    logic [3:0]  pred;
    logic [15:0] val;
    set_idling(sender_pct, receiver_pct);
    write_reg(CFG_SMALL_CODEC, small_sel);
    write_reg(CFG_PRED_COUNT, pred_count);
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        if (roll < 5) val = 16'($urandom);
        else val = 16'($urandom_range(8191) - 4096);
        send_coef(8'($urandom), val);
      end else begin
        if (roll < 25 && pred_count < MAX_PREDICTORS)
          pred = 4'($urandom_range(15, pred_count));
        else
          pred = 4'($urandom_range(pred_count - 1));
        send_frame({4'($urandom), pred}, {$urandom, $urandom}, $urandom_range(9) == 0);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0, 1'b0, MAX_PREDICTORS, 55);
    run_random_phase(78, 0, 1'b1, $urandom_range(15, 2), 55);
    run_random_phase(0, 78, 1'b0, 1, 55);
    run_random_phase(27, 27, 1'b1, MAX_PREDICTORS, 55);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    load_coefficients();
    test_no_predictors();
    test_four_bit();
    test_out_of_range();
    test_small_codec();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/vfd_pkg.sv
rtl/core/vfd_front.sv
rtl/core/vfd_queue.sv
rtl/core/vfd_back.sv
rtl/core/vadpcm_frame_decoder_unit.sv
tb/tb_vadpcm_frame_decoder_unit.sv
